// ----- design/tba_pkg.sv -----
// Shared types and constants for the dual token bucket admitter.
// Used by the controller, the datapath, the divider and the top level.
package tba_pkg;

    localparam int RATE_W   = 17;
    localparam int TIME_W   = 64;
    localparam int DIV_W    = 27;
    localparam int CNT_W    = 5;
    localparam int MS_W     = 10;
    localparam int ADD_W    = 35;
    localparam int RECIP_W  = 28;
    localparam int RECIP_SH = 37;
    localparam int PROD_W   = DIV_W + RECIP_W;

    localparam logic [MS_W-1:0]   MS_PER_S = 10'd1000;
    // 2^17 whole seconds in milliseconds: at or past this the refill saturates
    localparam logic [TIME_W-1:0] LONG_GAP = 64'd131072000;
    // ceil(2^37 / 1000): multiply and shift by 37 gives the exact quotient by 1000
    // for any 27-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_MS = 28'd137438954;

    localparam logic [RATE_W-1:0] LINK_RATE_RST = 17'd10;
    localparam logic [RATE_W-1:0] END_RATE_RST  = 17'd5;
    localparam logic [RATE_W-1:0] END_BURST_RST = 17'd20;

    localparam logic [1:0] REG_LINK_RATE = 2'd0;
    localparam logic [1:0] REG_END_RATE  = 2'd1;
    localparam logic [1:0] REG_END_BURST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_EVAL,
        S_DIV_Q,
        S_MUL_Q,
        S_MUL_R,
        S_DIV_F,
        S_ADD,
        S_CMP,
        S_TIME,
        S_DIV_T,
        S_SPEND
    } state_t;

    typedef struct packed {
        logic     load_req;
        logic     diff;
        logic     sec_div;
        logic     mul_q;
        logic     mul_r;
        logic     frac_div;
        logic     add_frac;
        logic     div_start;
        logic     prime;
        logic     fill;
        logic     accrue;
        logic     advance;
        logic     spend;
    } tba_cmd_t;

    typedef struct packed {
        logic primed;
        logic backward;
        logic rate_zero;
        logic long_gap;
        logic add_zero;
        logic full;
        logic div_done;
        logic out_free;
    } tba_status_t;

endpackage

// ----- design/tba_div.sv -----
// Restoring divider, one quotient bit per cycle, 27-bit dividend by 17-bit divisor.
// Depends on tba_pkg for widths.
module tba_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tba_pkg::DIV_W-1:0]    dividend,
    input  logic [tba_pkg::RATE_W-1:0]   divisor,
    output logic [tba_pkg::DIV_W-1:0]    quotient,
    output logic                         done
);

    logic                         busy_reg;
    logic [tba_pkg::CNT_W-1:0]    cnt_reg;
    logic                         done_reg;
    logic [tba_pkg::DIV_W-1:0]    quo_reg;
    logic [tba_pkg::RATE_W-1:0]   rem_reg;
    logic [tba_pkg::RATE_W-1:0]   den_reg;
    logic [tba_pkg::RATE_W:0]     trial;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[tba_pkg::DIV_W-1]} - {1'b0, den_reg};
    assign fits  = ~trial[tba_pkg::RATE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == tba_pkg::CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= tba_pkg::CNT_W'(tba_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - tba_pkg::CNT_W'(1);
                if (cnt_reg == tba_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            // shift the next dividend bit in, keep the difference if it fits
            quo_reg <= {quo_reg[tba_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? trial[tba_pkg::RATE_W-1:0]
                            : {rem_reg[tba_pkg::RATE_W-2:0], quo_reg[tba_pkg::DIV_W-1]};
        end
    end

    assign quotient  = quo_reg;
    assign done      = done_reg;

endmodule

// ----- design/tba_datapath.sv -----
// Datapath: configuration registers, both buckets, refill arithmetic, result register.
// Depends on tba_pkg and instantiates tba_div.
module tba_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tba_pkg::tba_cmd_t           cmd,
    output tba_pkg::tba_status_t        status,
    input  logic                        req_type,
    input  logic [tba_pkg::TIME_W-1:0]  now_ms,
    input  logic                        cfg_wr,
    input  logic [1:0]                  cfg_index,
    input  logic [tba_pkg::RATE_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_admitted,
    output logic [tba_pkg::RATE_W-1:0]  out_tokens
);

    logic [tba_pkg::RATE_W-1:0] link_rate_reg;
    logic [tba_pkg::RATE_W-1:0] end_rate_reg;
    logic [tba_pkg::RATE_W-1:0] end_burst_reg;

    logic [tba_pkg::RATE_W-1:0] tokens_reg [2];
    logic                       primed_reg [2];
    logic [tba_pkg::TIME_W-1:0] last_reg   [2];

    logic                       sel_reg;
    logic [tba_pkg::TIME_W-1:0] now_reg;
    logic [tba_pkg::TIME_W-1:0] elapsed_reg;
    logic                       backward_reg;
    logic [tba_pkg::RATE_W-1:0] sec_reg;
    logic [tba_pkg::MS_W-1:0]   ms_reg;
    logic [tba_pkg::RATE_W-1:0] frac_reg;
    logic [33:0]                acc_reg;
    logic [tba_pkg::DIV_W-1:0]  mul_reg;
    logic [tba_pkg::ADD_W-1:0]  add_reg;

    logic                       out_valid_reg;
    logic                       out_admitted_reg;
    logic [tba_pkg::RATE_W-1:0] out_tokens_reg;

    logic [tba_pkg::RATE_W-1:0] cur_tokens;
    logic [tba_pkg::TIME_W-1:0] cur_last;
    logic [tba_pkg::RATE_W-1:0] cur_rate;
    logic [tba_pkg::RATE_W-1:0] cur_cap;
    logic [tba_pkg::TIME_W:0]   diff;
    logic [tba_pkg::ADD_W:0]    sum;
    logic                       has_token;

    logic [tba_pkg::DIV_W-1:0]  recip_in;
    logic [tba_pkg::PROD_W-1:0] recip_prod;
    logic [tba_pkg::RATE_W-1:0] recip_quo;
    logic [tba_pkg::MS_W-1:0]   sec_ms;
    logic [tba_pkg::MS_W-1:0]   ms_left;

    logic [tba_pkg::DIV_W-1:0]  div_quo;
    logic                       div_done;

    logic [33:0]                prod_q;
    logic [tba_pkg::DIV_W-1:0]  prod_r;
    logic [tba_pkg::DIV_W-1:0]  prod_t;

    assign cur_tokens = tokens_reg[sel_reg];
    assign cur_last   = last_reg[sel_reg];
    assign cur_rate   = sel_reg ? end_rate_reg : link_rate_reg;
    assign cur_cap    = sel_reg ? end_burst_reg : link_rate_reg;
    assign diff       = {1'b0, now_reg} - {1'b0, cur_last};
    assign sum        = {19'd0, cur_tokens} + {1'b0, add_reg};
    assign has_token  = (cur_tokens != '0);

    // divide by 1000 through the reciprocal: whole seconds, then the fractional credit
    assign recip_in   = cmd.frac_div ? mul_reg : elapsed_reg[tba_pkg::DIV_W-1:0];
    assign recip_prod = recip_in * tba_pkg::RECIP_MS;
    assign recip_quo  = recip_prod[tba_pkg::RECIP_SH +: tba_pkg::RATE_W];

    // leftover milliseconds are below 1000, so the low bits carry them exactly
    assign sec_ms  = tba_pkg::MS_W'(sec_reg * tba_pkg::MS_PER_S);
    assign ms_left = elapsed_reg[tba_pkg::MS_W-1:0] - sec_ms;

    assign prod_q = sec_reg * cur_rate;
    assign prod_r = ms_reg * cur_rate;
    assign prod_t = add_reg[tba_pkg::RATE_W-1:0] * tba_pkg::MS_PER_S;

    tba_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mul_reg),
        .divisor   (cur_rate),
        .quotient  (div_quo),
        .done      (div_done)
    );

    // configuration, bucket state and the result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_rate_reg <= tba_pkg::LINK_RATE_RST;
            end_rate_reg  <= tba_pkg::END_RATE_RST;
            end_burst_reg <= tba_pkg::END_BURST_RST;
            tokens_reg[0] <= tba_pkg::LINK_RATE_RST;
            tokens_reg[1] <= tba_pkg::END_BURST_RST;
            primed_reg[0] <= 1'b0;
            primed_reg[1] <= 1'b0;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    tba_pkg::REG_LINK_RATE: link_rate_reg <= cfg_data;
                    tba_pkg::REG_END_RATE:  end_rate_reg  <= cfg_data;
                    tba_pkg::REG_END_BURST: end_burst_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.prime) begin
                primed_reg[sel_reg] <= 1'b1;
                last_reg[sel_reg]   <= now_reg;
            end
            if (cmd.fill) begin
                tokens_reg[sel_reg] <= cur_cap;
                last_reg[sel_reg]   <= now_reg;
            end
            if (cmd.accrue) begin
                tokens_reg[sel_reg] <= cur_tokens + add_reg[tba_pkg::RATE_W-1:0];
            end
            if (cmd.advance) begin
                last_reg[sel_reg] <= cur_last + {37'd0, div_quo};
            end
            if (cmd.spend && has_token) begin
                tokens_reg[sel_reg] <= cur_tokens - tba_pkg::RATE_W'(1);
            end
            if (cmd.spend) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the refill computation
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            sel_reg <= req_type;
            now_reg <= now_ms;
        end
        if (cmd.diff) begin
            elapsed_reg  <= diff[tba_pkg::TIME_W-1:0];
            backward_reg <= diff[tba_pkg::TIME_W];
        end
        if (cmd.sec_div) begin
            sec_reg <= recip_quo;
        end
        if (cmd.mul_q) begin
            acc_reg <= prod_q;
            ms_reg  <= ms_left;
        end
        if (cmd.mul_r) begin
            mul_reg <= prod_r;
        end
        if (cmd.frac_div) begin
            frac_reg <= recip_quo;
        end
        if (cmd.accrue) begin
            mul_reg <= prod_t;
        end
        if (cmd.add_frac) begin
            add_reg <= {1'b0, acc_reg} + {18'd0, frac_reg};
        end
        if (cmd.spend) begin
            out_admitted_reg <= has_token;
            out_tokens_reg   <= has_token ? cur_tokens - tba_pkg::RATE_W'(1) : cur_tokens;
        end
    end

    assign status.primed    = primed_reg[sel_reg];
    assign status.backward  = backward_reg;
    assign status.rate_zero = (cur_rate == '0);
    assign status.long_gap  = (elapsed_reg >= tba_pkg::LONG_GAP);
    assign status.add_zero  = (add_reg == '0);
    assign status.full      = (sum >= {19'd0, cur_cap});
    assign status.div_done  = div_done;
    assign status.out_free  = ~out_valid_reg | out_ready;

    assign out_valid    = out_valid_reg;
    assign out_admitted = out_admitted_reg;
    assign out_tokens   = out_tokens_reg;

endmodule

// ----- design/tba_ctrl.sv -----
// Controller: sequences one request through refill, spend and result load.
// Depends on tba_pkg for the state, command and status types.
module tba_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tba_pkg::tba_status_t   status,
    output tba_pkg::tba_cmd_t      cmd
);

    tba_pkg::state_t state_reg;
    tba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tba_pkg::S_IDLE:  if (in_valid) state_next = tba_pkg::S_DIFF;
            tba_pkg::S_DIFF:  state_next = tba_pkg::S_EVAL;
            tba_pkg::S_EVAL: begin
                if (!status.primed || status.backward || status.rate_zero ||
                    status.long_gap) begin
                    state_next = tba_pkg::S_SPEND;
                end else begin
                    state_next = tba_pkg::S_DIV_Q;
                end
            end
            tba_pkg::S_DIV_Q: state_next = tba_pkg::S_MUL_Q;
            tba_pkg::S_MUL_Q: state_next = tba_pkg::S_MUL_R;
            tba_pkg::S_MUL_R: state_next = tba_pkg::S_DIV_F;
            tba_pkg::S_DIV_F: state_next = tba_pkg::S_ADD;
            tba_pkg::S_ADD:   state_next = tba_pkg::S_CMP;
            tba_pkg::S_CMP: begin
                if (status.add_zero || status.full) begin
                    state_next = tba_pkg::S_SPEND;
                end else begin
                    state_next = tba_pkg::S_TIME;
                end
            end
            tba_pkg::S_TIME:  state_next = tba_pkg::S_DIV_T;
            tba_pkg::S_DIV_T: if (status.div_done) state_next = tba_pkg::S_SPEND;
            tba_pkg::S_SPEND: if (status.out_free) state_next = tba_pkg::S_IDLE;
            default:          state_next = tba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tba_pkg::S_IDLE: begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            tba_pkg::S_DIFF: cmd.diff = 1'b1;
            tba_pkg::S_EVAL: begin
                if (!status.primed) begin
                    cmd.prime = 1'b1;
                end else if (status.backward || status.rate_zero) begin
                    cmd.prime = 1'b0;
                end else if (status.long_gap) begin
                    cmd.fill = 1'b1;
                end
            end
            tba_pkg::S_DIV_Q: cmd.sec_div  = 1'b1;
            tba_pkg::S_MUL_Q: cmd.mul_q    = 1'b1;
            tba_pkg::S_MUL_R: cmd.mul_r    = 1'b1;
            tba_pkg::S_DIV_F: cmd.frac_div = 1'b1;
            tba_pkg::S_ADD:   cmd.add_frac = 1'b1;
            tba_pkg::S_CMP: begin
                // zero credit leaves the bucket as it is
                if (!status.add_zero) begin
                    cmd.fill   = status.full;
                    cmd.accrue = ~status.full;
                end
            end
            tba_pkg::S_TIME:  cmd.div_start = 1'b1;
            tba_pkg::S_DIV_T: cmd.advance   = status.div_done;
            tba_pkg::S_SPEND: cmd.spend     = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- design/dual_token_bucket_admitter_top.sv -----
// Requests go through S_DIFF and S_EVAL to S_SPEND when the bucket is being primed,
// the clock ran backwards, the rate is zero or the gap saturates the refill; through
// S_DIV_Q to S_CMP when the refill fills the bucket or credits nothing; and on to
// S_TIME and S_DIV_T on a partial refill. Both divisions by 1000 are combinational
// reciprocal multiplies; the 27-step divider by the rate runs once for the time
// consumed by the credit. One request is in work at a time; the next is accepted
// while the last result waits in the output register; cfg writes are always taken.
module dual_token_bucket_admitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // now_ms
    input  logic [0:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // tokens_left, zero padded
    output logic [0:0]  m_tuser,    // admitted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    tba_pkg::tba_cmd_t    cmd;
    tba_pkg::tba_status_t status;
    logic                 out_admitted;
    logic [16:0]          out_tokens;

    assign cfg_ready = 1'b1;

    tba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tba_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .req_type     (s_tuser[0]),
        .now_ms       (s_tdata),
        .cfg_wr       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_admitted (out_admitted),
        .out_tokens   (out_tokens)
    );

    assign m_tdata = {7'd0, out_tokens};
    assign m_tuser = out_admitted;

endmodule

// ----- design/tba_checker.sv -----
// Port-level checks for the admitter, bound to the top level.
// Depends only on the top level's ports.
module tba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a denied request leaves an empty bucket
    a_deny_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("denied item reports tokens left");

    // one request in work at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted during work");

    a_reset_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_tready && !m_tvalid)
        else $error("bad state after reset");

endmodule

bind dual_token_bucket_admitter_top tba_checker u_tba_checker (.*);

// ----- sim/tb_dual_token_bucket_admitter_top.sv -----
// Self-checking testbench for dual_token_bucket_admitter_top.
// Holds its own bucket predictor and compares every result item against it;
// needs only tba_pkg and the top level.
module tb_dual_token_bucket_admitter_top;

    localparam logic [63:0] MS_PER_SEC     = 64'd1000;
    localparam logic [63:0] SATURATE_SECS  = 64'd131072;
    localparam logic [63:0] SATURATE_MS    = 64'd131072000;
    localparam logic [63:0] TIME_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  REG_UNUSED     = 2'd3;
    localparam logic [16:0] FIELD_MAX      = 17'h1FFFF;
    localparam int          IDLE_PCT       = 33;
    localparam int          SETTLE_CYCLES  = 100;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          PHASE_ITEMS    = 170;

    typedef enum bit {LINK_RESUME, END_RESUME} bucket_t;

    typedef struct packed {
        logic        admitted;
        logic [16:0] tokens_left;
    } verdict_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // now_ms
    logic [0:0]  s_tuser   = '0;    // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // tokens_left, zero padded
    logic [0:0]  m_tuser;           // admitted
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;

    // predicted register and bucket state
    logic [16:0] link_rate_q;
    logic [16:0] end_rate_q;
    logic [16:0] end_burst_q;
    logic [16:0] bkt_tokens [2];
    bit          bkt_primed [2];
    logic [63:0] bkt_stamp  [2];

    verdict_t    pending_verdicts [$];
    logic [63:0] req_clock [2];     // highest timestamp sent to each bucket
    bit          no_gaps = 1'b0;
    int          fail_count = 0;
    int          sent_count = 0;
    int          granted_count = 0;
    int          denied_count = 0;
    int          cfg_writes = 0;

    dual_token_bucket_admitter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void reset_predictor();
        link_rate_q = tba_pkg::LINK_RATE_RST;
        end_rate_q  = tba_pkg::END_RATE_RST;
        end_burst_q = tba_pkg::END_BURST_RST;
        bkt_tokens[0] = tba_pkg::LINK_RATE_RST;
        bkt_tokens[1] = tba_pkg::END_BURST_RST;
        for (int i = 0; i < 2; i++) begin
            bkt_primed[i] = 1'b0;
            bkt_stamp[i]  = '0;
            req_clock[i]  = '0;
        end
    endfunction

    function automatic void refill_bucket(bucket_t kind, logic [63:0] now);
        logic [16:0] rate;
        logic [16:0] cap;
        logic [63:0] elapsed;
        logic [63:0] secs;
        logic [63:0] credit;
        int          b;
        b    = int'(kind);
        rate = (kind == END_RESUME) ? end_rate_q : link_rate_q;
        cap  = (kind == END_RESUME) ? end_burst_q : link_rate_q;
        // first request only starts the bucket clock
        if (!bkt_primed[b]) begin
            bkt_primed[b] = 1'b1;
            bkt_stamp[b]  = now;
            return;
        end
        if (now < bkt_stamp[b] || rate == 17'd0)
            return;
        elapsed = now - bkt_stamp[b];
        secs    = elapsed / MS_PER_SEC;
        if (secs >= SATURATE_SECS) begin
            bkt_tokens[b] = cap;
            bkt_stamp[b]  = now;
            return;
        end
        credit = secs * {47'd0, rate} + ((elapsed % MS_PER_SEC) * {47'd0, rate}) / MS_PER_SEC;
        if (credit == 64'd0)
            return;
        if ({47'd0, bkt_tokens[b]} + credit >= {47'd0, cap}) begin
            bkt_tokens[b] = cap;
            bkt_stamp[b]  = now;
        end else begin
            // keep the leftover fraction: advance only by the credited time
            bkt_tokens[b] = bkt_tokens[b] + credit[16:0];
            bkt_stamp[b]  = bkt_stamp[b] + (credit * MS_PER_SEC) / {47'd0, rate};
        end
    endfunction

    function automatic verdict_t predict_admission(bucket_t kind, logic [63:0] now);
        verdict_t v;
        int       b;
        b = int'(kind);
        refill_bucket(kind, now);
        v.admitted = (bkt_tokens[b] != 17'd0);
        if (v.admitted)
            bkt_tokens[b] = bkt_tokens[b] - 17'd1;
        v.tokens_left = bkt_tokens[b];
        return v;
    endfunction

    task automatic send_request(bucket_t kind, logic [63:0] now);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(predict_admission(kind, now));
        if (now > req_clock[int'(kind)])
            req_clock[int'(kind)] = now;
        sent_count++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tba_pkg::REG_LINK_RATE: link_rate_q = value;
            tba_pkg::REG_END_RATE:  end_rate_q  = value;
            tba_pkg::REG_END_BURST: end_burst_q = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // result checker and receiver-side stalls
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: admitted=%0d tokens=%0d", m_tuser[0],
                             m_tdata[16:0]);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tuser[0] !== want.admitted || m_tdata !== {7'd0, want.tokens_left}) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected admitted=%0d tdata=%0h,",
                                 want.admitted, {7'd0, want.tokens_left},
                                 " got admitted=%0d tdata=%0h", m_tuser[0], m_tdata);
                end
                if (want.admitted)
                    granted_count++;
                else
                    denied_count++;
            end
        end
        m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic test_first_requests();
        send_request(LINK_RESUME, 64'd0);
        send_request(END_RESUME, 64'd1000);
    endtask

    task automatic test_backwards_clock();
        send_request(END_RESUME, 64'd0);
    endtask

    task automatic test_refill_carry();
        send_request(LINK_RESUME, 64'd100);   // refill hits capacity
        send_request(LINK_RESUME, 64'd150);   // too little time for a token
        send_request(LINK_RESUME, 64'd250);   // partial refill, carry the rest
        send_request(END_RESUME, 64'd1199);
        send_request(END_RESUME, 64'd1400);
        send_request(END_RESUME, 64'd1300);   // behind the advanced stamp
    endtask

    task automatic test_long_gap();
        logic [63:0] base;
        base = req_clock[int'(LINK_RESUME)];
        send_request(LINK_RESUME, base + SATURATE_MS);
        base = req_clock[int'(LINK_RESUME)];
        send_request(LINK_RESUME, base + SATURATE_MS - 64'd1);
    endtask

    task automatic test_register_extremes();
        write_reg(tba_pkg::REG_LINK_RATE, 17'd0);
        write_reg(tba_pkg::REG_END_BURST, 17'd0);
        write_reg(tba_pkg::REG_END_RATE, FIELD_MAX);
        send_request(LINK_RESUME, req_clock[int'(LINK_RESUME)] + 64'd5000);
        send_request(END_RESUME, req_clock[int'(END_RESUME)] + 64'd1000);
        send_request(END_RESUME, req_clock[int'(END_RESUME)]);
    endtask

    task automatic test_ignored_register();
        write_reg(REG_UNUSED, FIELD_MAX);
        send_request(END_RESUME, req_clock[int'(END_RESUME)] + 64'd10);
    endtask

    task automatic run_random_phase(int items, logic [16:0] lrate, logic [16:0] erate,
                                    logic [16:0] eburst, bit steady);
        bucket_t     kind;
        logic [63:0] base;
        logic [63:0] gap;
        logic [63:0] now;
        int          roll;
        int          pick;
        write_reg(tba_pkg::REG_LINK_RATE, lrate);
        write_reg(tba_pkg::REG_END_RATE, erate);
        write_reg(tba_pkg::REG_END_BURST, eburst);
        no_gaps = steady;
        repeat (items) begin
            kind = $urandom_range(1) ? END_RESUME : LINK_RESUME;
            base = req_clock[int'(kind)];
            roll = $urandom_range(99);
            if (roll < 85) begin
                pick = $urandom_range(99);
                if (pick < 25)
                    gap = 64'd0;
                else if (pick < 55)
                    gap = 64'($urandom_range(99, 1));
                else if (pick < 85)
                    gap = 64'($urandom_range(3000, 100));
                else if (pick < 97)
                    gap = 64'($urandom_range(200000, 3001));
                else
                    gap = SATURATE_MS + 64'($urandom_range(1000000));
                now = base + gap;
            end else if (roll < 95 && base != 64'd0) begin
                now = base - 64'd1 - ({$urandom, $urandom} % base);
            end else begin
                now = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF;
            end
            send_request(kind, now);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(PHASE_ITEMS, tba_pkg::LINK_RATE_RST, tba_pkg::END_RATE_RST,
                         tba_pkg::END_BURST_RST, 1'b0);
        run_random_phase(PHASE_ITEMS, 17'd1, 17'd1, 17'd1, 1'b0);
        run_random_phase(PHASE_ITEMS, 17'd100000, 17'd100000, FIELD_MAX, 1'b1);
        run_random_phase(PHASE_ITEMS, 17'($urandom_range(2000, 1)),
                         17'($urandom_range(2000, 1)), 17'($urandom_range(60)), 1'b0);
        run_random_phase(PHASE_ITEMS, 17'($urandom_range(50, 1)), 17'd0, 17'd100000, 1'b0);
    endtask

    task automatic test_time_extremes();
        send_request(LINK_RESUME, TIME_MAX);
        send_request(END_RESUME, TIME_MAX);
        send_request(LINK_RESUME, 64'h8000_0000_0000_0000);
        send_request(END_RESUME, TIME_MAX);
    endtask

    initial begin
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_requests();
        test_backwards_clock();
        test_refill_carry();
        test_long_gap();
        test_register_extremes();
        test_ignored_register();
        test_random_traffic();
        test_time_extremes();
        wait_for_drain();
        $display("Sent %0d requests across both buckets with %0d register writes;", sent_count,
                 cfg_writes);
        $display("checked %0d admits and %0d denials, %0d failures.", granted_count,
                 denied_count, fail_count);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("run stopped: timeout with %0d results outstanding", pending_verdicts.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- dual_token_bucket_admitter_top.f -----
design/tba_pkg.sv
design/tba_div.sv
design/tba_datapath.sv
design/tba_ctrl.sv
design/dual_token_bucket_admitter_top.sv
design/tba_checker.sv
sim/tb_dual_token_bucket_admitter_top.sv
